>>> rtl/core/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 16;

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/directional_focus_search.sv
// flow: a start beat is done in the feature state, a candidate passes the features, squares,
// weighted sums and decision states; either can wait in the two-beat input queue or for the output to be taken
// the back-end sequencer (features, squares, weighted sums, decision) handles one beat at a time
// and takes no new beat while a result is still waiting to be taken
// reset: asynchronous, clears the queue, the sequencer, the output beat and the search
// state; no clearing pass, the block takes beats right after reset
`default_nettype none

module directional_focus_search #(
  parameter int unsigned COORD_BITS = dfs_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = dfs_pkg::ID_BITS_DEF,
  localparam int unsigned IN_BITS   = 4 * COORD_BITS + ID_BITS,
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS  = 1 + ID_BITS,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // direction, rect_left, rect_top, rect_width, rect_height, cand_id, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  // opcode
  input  logic             s_axis_tuser,
  // last_item
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // found, best_id, zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);
  import dfs_pkg::*;

  localparam int unsigned OFS_LEFT   = 2;
  localparam int unsigned OFS_TOP    = OFS_LEFT + COORD_BITS;
  localparam int unsigned OFS_WIDTH  = OFS_TOP + COORD_BITS;
  localparam int unsigned OFS_HEIGHT = OFS_WIDTH + COORD_BITS - 1;
  localparam int unsigned OFS_ID     = OFS_HEIGHT + COORD_BITS - 1;

  logic                item_valid, item_ready, item_cand, item_last;
  logic [1:0]          item_dir;
  logic [COORD_BITS:0] item_l, item_t, item_r, item_b;
  logic [ID_BITS-1:0]  item_id;
  logic                res_found;
  logic [ID_BITS-1:0]  res_id;

  dfs_front #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_dir_i    (s_axis_tdata[1:0]),
    .in_left_i   (s_axis_tdata[OFS_LEFT +: COORD_BITS]),
    .in_top_i    (s_axis_tdata[OFS_TOP +: COORD_BITS]),
    .in_width_i  (s_axis_tdata[OFS_WIDTH +: COORD_BITS-1]),
    .in_height_i (s_axis_tdata[OFS_HEIGHT +: COORD_BITS-1]),
    .in_id_i     (s_axis_tdata[OFS_ID +: ID_BITS]),
    .in_last_i   (s_axis_tlast),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_cand_o (item_cand),
    .item_dir_o  (item_dir),
    .item_l_o    (item_l),
    .item_t_o    (item_t),
    .item_r_o    (item_r),
    .item_b_o    (item_b),
    .item_id_o   (item_id),
    .item_last_o (item_last)
  );

  dfs_back #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_cand_i (item_cand),
    .item_dir_i  (item_dir),
    .item_l_i    (item_l),
    .item_t_i    (item_t),
    .item_r_i    (item_r),
    .item_b_i    (item_b),
    .item_id_i   (item_id),
    .item_last_i (item_last),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_found_o (res_found),
    .res_id_o    (res_id)
  );

  assign m_axis_tdata = OUT_W'({res_id, res_found});

`ifndef ASSERT_OFF
  // the back end never starts a beat while a result is still pending
  a_no_pop_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && item_ready) |-> !m_axis_tvalid)
    else $error("back end took a beat while a result was pending");

  // a full queue always offers its head to the back end
  a_full_queue_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> item_valid)
    else $error("input stalled with nothing queued");

  // no best found means the id reads as zero
  a_empty_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_found) |-> (res_id == '0))
    else $error("nonzero id without a found best");

  // a new result only appears after the back end was busy with a beat
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!item_ready))
    else $error("result appeared while the back end was idle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/dfs_front.sv
`default_nettype none

module dfs_front #(
  parameter int unsigned COORD_BITS = dfs_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = dfs_pkg::ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_opcode_i,
  input  logic [1:0]            in_dir_i,
  input  logic [COORD_BITS-1:0] in_left_i,
  input  logic [COORD_BITS-1:0] in_top_i,
  input  logic [COORD_BITS-2:0] in_width_i,
  input  logic [COORD_BITS-2:0] in_height_i,
  input  logic [ID_BITS-1:0]    in_id_i,
  input  logic                  in_last_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output logic                  item_cand_o,
  output logic [1:0]            item_dir_o,
  output logic [COORD_BITS:0]   item_l_o,
  output logic [COORD_BITS:0]   item_t_o,
  output logic [COORD_BITS:0]   item_r_o,
  output logic [COORD_BITS:0]   item_b_o,
  output logic [ID_BITS-1:0]    item_id_o,
  output logic                  item_last_o
);
  import dfs_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic                  cand_mem [Q_DEPTH];
  logic [1:0]            dir_mem  [Q_DEPTH];
  logic [COORD_BITS:0]   l_mem    [Q_DEPTH];
  logic [COORD_BITS:0]   t_mem    [Q_DEPTH];
  logic [COORD_BITS:0]   r_mem    [Q_DEPTH];
  logic [COORD_BITS:0]   b_mem    [Q_DEPTH];
  logic [ID_BITS-1:0]    id_mem   [Q_DEPTH];
  logic                  last_mem [Q_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic push, pop;
  logic [COORD_BITS:0] left_x, top_x, right_x, bottom_x;

  // edges of the item, one bit wider than the coordinates
  assign left_x   = {in_left_i[COORD_BITS-1], in_left_i};
  assign top_x    = {in_top_i[COORD_BITS-1], in_top_i};
  assign right_x  = left_x + {2'b00, in_width_i};
  assign bottom_x = top_x + {2'b00, in_height_i};

  assign in_ready_o   = (cnt_q != CNT_W'(Q_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cand_mem[wr_ptr_q] <= (in_opcode_i == OP_CAND);
      dir_mem[wr_ptr_q]  <= in_dir_i;
      l_mem[wr_ptr_q]    <= left_x;
      t_mem[wr_ptr_q]    <= top_x;
      r_mem[wr_ptr_q]    <= right_x;
      b_mem[wr_ptr_q]    <= bottom_x;
      id_mem[wr_ptr_q]   <= in_id_i;
      last_mem[wr_ptr_q] <= in_last_i;
    end
  end

  assign item_cand_o = cand_mem[rd_ptr_q];
  assign item_dir_o  = dir_mem[rd_ptr_q];
  assign item_l_o    = l_mem[rd_ptr_q];
  assign item_t_o    = t_mem[rd_ptr_q];
  assign item_r_o    = r_mem[rd_ptr_q];
  assign item_b_o    = b_mem[rd_ptr_q];
  assign item_id_o   = id_mem[rd_ptr_q];
  assign item_last_o = last_mem[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/core/dfs_back.sv
`default_nettype none

module dfs_back #(
  parameter int unsigned COORD_BITS = dfs_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = dfs_pkg::ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  logic                item_cand_i,
  input  logic [1:0]          item_dir_i,
  input  logic [COORD_BITS:0] item_l_i,
  input  logic [COORD_BITS:0] item_t_i,
  input  logic [COORD_BITS:0] item_r_i,
  input  logic [COORD_BITS:0] item_b_i,
  input  logic [ID_BITS-1:0]  item_id_i,
  input  logic                item_last_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                res_found_o,
  output logic [ID_BITS-1:0]  res_id_o
);
  import dfs_pkg::*;

  // best edges can move one extent plus one beyond the coordinate range
  localparam int unsigned EW = COORD_BITS + 2;
  localparam int unsigned DW = EW + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned WW = SW + 4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FEAT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;

  typedef logic [EW-1:0] coord_t;
  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  function automatic logic signed [DW-1:0] sx(coord_t x);
    sx = {x[EW-1], x};
  endfunction

  function automatic logic f_in_dir(logic [1:0] d, box_t s, box_t c);
    logic res;
    unique case (d)
      DIR_LEFT:  res = (sx(s.r) > sx(c.r) || sx(s.l) >= sx(c.r)) && sx(s.l) > sx(c.l);
      DIR_RIGHT: res = (sx(s.l) < sx(c.l) || sx(s.r) <= sx(c.l)) && sx(s.r) < sx(c.r);
      DIR_UP:    res = (sx(s.b) > sx(c.b) || sx(s.t) >= sx(c.b)) && sx(s.t) > sx(c.t);
      default:   res = (sx(s.t) < sx(c.t) || sx(s.b) <= sx(c.t)) && sx(s.b) < sx(c.b);
    endcase
    return res;
  endfunction

  function automatic logic f_in_beam(logic [1:0] d, box_t s, box_t c);
    logic res;
    if (d == DIR_LEFT || d == DIR_RIGHT) begin
      res = sx(c.b) >= sx(s.t) && sx(c.t) <= sx(s.b);
    end else begin
      res = sx(c.r) >= sx(s.l) && sx(c.l) <= sx(s.r);
    end
    return res;
  endfunction

  function automatic logic f_fully(logic [1:0] d, box_t s, box_t c);
    logic res;
    unique case (d)
      DIR_LEFT:  res = sx(s.l) >= sx(c.r);
      DIR_RIGHT: res = sx(s.r) <= sx(c.l);
      DIR_UP:    res = sx(s.t) >= sx(c.b);
      default:   res = sx(s.b) <= sx(c.t);
    endcase
    return res;
  endfunction

  function automatic logic [DW-1:0] f_near(logic [1:0] d, box_t s, box_t c);
    logic signed [DW-1:0] v;
    unique case (d)
      DIR_LEFT:  v = sx(s.l) - sx(c.r);
      DIR_RIGHT: v = sx(c.l) - sx(s.r);
      DIR_UP:    v = sx(s.t) - sx(c.b);
      default:   v = sx(c.t) - sx(s.b);
    endcase
    return v[DW-1] ? '0 : v;
  endfunction

  function automatic logic [DW-1:0] f_far(logic [1:0] d, box_t s, box_t c);
    logic signed [DW-1:0] v;
    unique case (d)
      DIR_LEFT:  v = sx(s.l) - sx(c.l);
      DIR_RIGHT: v = sx(c.r) - sx(s.r);
      DIR_UP:    v = sx(s.t) - sx(c.t);
      default:   v = sx(c.b) - sx(s.b);
    endcase
    return (v[DW-1] || v == '0) ? DW'(1) : v;
  endfunction

  // extents are never negative, so the halving shift truncates like a divide
  function automatic logic signed [DW-1:0] f_center(coord_t lo, coord_t hi);
    logic signed [DW-1:0] span;
    span = sx(hi) - sx(lo);
    return sx(lo) + (span >>> 1);
  endfunction

  function automatic logic [DW-1:0] f_minor(logic [1:0] d, box_t s, box_t c);
    logic signed [DW-1:0] v;
    if (d == DIR_LEFT || d == DIR_RIGHT) begin
      v = f_center(s.t, s.b) - f_center(c.t, c.b);
    end else begin
      v = f_center(s.l, s.r) - f_center(c.l, c.r);
    end
    return v[DW-1] ? -v : v;
  endfunction

  function automatic logic [SW-1:0] f_sq(logic [DW-1:0] x);
    logic [SW-1:0] xe;
    xe = {{DW{1'b0}}, x};
    return xe * xe;
  endfunction

  function automatic logic [WW-1:0] f_wt(logic [SW-1:0] mj2, logic [SW-1:0] mn2);
    logic [WW-1:0] a;
    logic [WW-1:0] b;
    a = {4'b0000, mj2};
    b = {4'b0000, mn2};
    return (a << 3) + (a << 2) + a + b;
  endfunction

  logic [2:0] state_q, state_d;

  // search state
  logic [1:0]         dir_q, dir_d;
  box_t               src_q, src_d;
  box_t               best_q, best_d;
  logic [ID_BITS-1:0] ident_q, ident_d;
  logic               have_q, have_d;

  // item in work
  box_t               cur_q;
  logic               cur_cand_q;
  logic [1:0]         cur_dir_q;
  logic [ID_BITS-1:0] cur_id_q;
  logic               cur_last_q;

  // per-candidate features, a is the candidate and o the stored best
  logic          dir_a_q, dir_o_q, beam_a_q, beam_o_q, full_a_q, full_o_q;
  logic [DW-1:0] near_a_q, near_o_q, far_a_q, far_o_q, minor_a_q, minor_o_q;
  logic          bw_ao_q, bw_oa_q;
  logic [SW-1:0] sq_mj_a_q, sq_mn_a_q, sq_mj_o_q, sq_mn_o_q;
  logic [WW-1:0] wt_a_q, wt_o_q;

  logic               res_valid_q, res_valid_d;
  logic               res_found_q, res_found_d;
  logic [ID_BITS-1:0] res_id_q, res_id_d;

  logic   pop, horiz, win;
  coord_t step_w, step_h;

  assign item_ready_o = (state_q == ST_IDLE) && !res_valid_q;
  assign pop          = item_valid_i && item_ready_o;
  assign horiz        = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT);
  assign step_w       = cur_q.r - cur_q.l + 1'b1;
  assign step_h       = cur_q.b - cur_q.t + 1'b1;

  always_comb begin
    if (!dir_a_q) begin
      win = 1'b0;
    end else if (!dir_o_q) begin
      win = 1'b1;
    end else if (bw_ao_q) begin
      win = 1'b1;
    end else if (bw_oa_q) begin
      win = 1'b0;
    end else begin
      win = wt_a_q < wt_o_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    src_d       = src_q;
    best_d      = best_q;
    ident_d     = ident_q;
    have_d      = have_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_found_d = res_found_q;
    res_id_d    = res_id_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d = ST_FEAT;
        end
      end
      ST_FEAT: begin
        if (cur_cand_q) begin
          state_d = ST_MUL;
        end else begin
          // start: best sits just behind the source so any real candidate wins
          dir_d   = cur_dir_q;
          src_d   = cur_q;
          best_d  = cur_q;
          ident_d = '0;
          have_d  = 1'b0;
          unique case (cur_dir_q)
            DIR_LEFT: begin
              best_d.l = cur_q.l + step_w;
              best_d.r = cur_q.r + step_w;
            end
            DIR_RIGHT: begin
              best_d.l = cur_q.l - step_w;
              best_d.r = cur_q.r - step_w;
            end
            DIR_UP: begin
              best_d.t = cur_q.t + step_h;
              best_d.b = cur_q.b + step_h;
            end
            default: begin
              best_d.t = cur_q.t - step_h;
              best_d.b = cur_q.b - step_h;
            end
          endcase
          if (cur_last_q) begin
            res_valid_d = 1'b1;
            res_found_d = 1'b0;
            res_id_d    = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (win) begin
          best_d  = cur_q;
          ident_d = cur_id_q;
          have_d  = 1'b1;
        end
        if (cur_last_q) begin
          res_valid_d = 1'b1;
          res_found_d = win || have_q;
          res_id_d    = win ? cur_id_q : ident_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= DIR_LEFT;
      src_q       <= '0;
      best_q      <= '0;
      ident_q     <= '0;
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      src_q       <= src_d;
      best_q      <= best_d;
      ident_q     <= ident_d;
      have_q      <= have_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_id_q    <= res_id_d;
    if (pop) begin
      cur_q.l    <= {item_l_i[COORD_BITS], item_l_i};
      cur_q.t    <= {item_t_i[COORD_BITS], item_t_i};
      cur_q.r    <= {item_r_i[COORD_BITS], item_r_i};
      cur_q.b    <= {item_b_i[COORD_BITS], item_b_i};
      cur_cand_q <= item_cand_i;
      cur_dir_q  <= item_dir_i;
      cur_id_q   <= item_id_i;
      cur_last_q <= item_last_i;
    end
    if (state_q == ST_FEAT) begin
      dir_a_q   <= f_in_dir(dir_q, src_q, cur_q);
      dir_o_q   <= f_in_dir(dir_q, src_q, best_q);
      beam_a_q  <= f_in_beam(dir_q, src_q, cur_q);
      beam_o_q  <= f_in_beam(dir_q, src_q, best_q);
      full_a_q  <= f_fully(dir_q, src_q, cur_q);
      full_o_q  <= f_fully(dir_q, src_q, best_q);
      near_a_q  <= f_near(dir_q, src_q, cur_q);
      near_o_q  <= f_near(dir_q, src_q, best_q);
      far_a_q   <= f_far(dir_q, src_q, cur_q);
      far_o_q   <= f_far(dir_q, src_q, best_q);
      minor_a_q <= f_minor(dir_q, src_q, cur_q);
      minor_o_q <= f_minor(dir_q, src_q, best_q);
    end
    if (state_q == ST_MUL) begin
      // beam win of one over the other, far-edge limit only for up and down
      bw_ao_q   <= !beam_o_q && beam_a_q && (!full_o_q || horiz || near_a_q < far_o_q);
      bw_oa_q   <= !beam_a_q && beam_o_q && (!full_a_q || horiz || near_o_q < far_a_q);
      sq_mj_a_q <= f_sq(near_a_q);
      sq_mn_a_q <= f_sq(minor_a_q);
      sq_mj_o_q <= f_sq(near_o_q);
      sq_mn_o_q <= f_sq(minor_o_q);
    end
    if (state_q == ST_SUM) begin
      wt_a_q <= f_wt(sq_mj_a_q, sq_mn_a_q);
      wt_o_q <= f_wt(sq_mj_o_q, sq_mn_o_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_found_o = res_found_q;
  assign res_id_o    = res_id_q;

endmodule

`default_nettype wire
